### hw/rtl/pc_discontinuity_trace_encoder_assert.svh
// ----------------------------------------------------------------------------
// pc discontinuity trace encoder assertion macros
// shared concurrent assertion forms for the encoder rtl
// ----------------------------------------------------------------------------
`ifndef PC_DISCONTINUITY_TRACE_ENCODER_ASSERT_SVH
`define PC_DISCONTINUITY_TRACE_ENCODER_ASSERT_SVH

// property that must hold at every edge out of reset
`define PDTE_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PDTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pdte_pkg.sv
// ----------------------------------------------------------------------------
// pdte_pkg
// shared constants and types for the pc discontinuity trace encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdte_pkg;

	localparam int PC_WIDTH_DEF = 32;
	localparam int WORD_W       = 32;
	localparam int COUNT_W      = 16;
	localparam int PADDR_W      = 2;
	localparam int PDATA_W      = 32;
	localparam int PC_STEP      = 4;
	localparam logic [COUNT_W-1:0] MAX_DISC_RST = '1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} entry_t;

	// up to two words per item, the second one always closes the item
	typedef struct packed {
		logic              push0;
		logic              push1;
		logic [WORD_W-1:0] word0;
		logic              last0;
		logic [WORD_W-1:0] word1;
	} push_t;

endpackage

`default_nettype wire

### hw/rtl/pc_discontinuity_trace_encoder.sv
// ----------------------------------------------------------------------------
// pc_discontinuity_trace_encoder
// branch trace compressor over retired next-pc values
// ----------------------------------------------------------------------------
//  channel   | handshake                          | payload
//  item      | item_valid / item_stall            | req_type, next_pc
//  word      | word_valid / word_stall            | trace_word, last_word
//  apb       | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
//  one item accepted per cycle while item_stall is low, held in the input
//  register; a jump yields two words into the result queue and the word port
//  drains one per cycle while word_stall is low, so back-to-back jumps stall
//  items. the four-entry result queue sets when item_stall rises
//  reset clears the trace state and sets the limit to 65535
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pc_discontinuity_trace_encoder #(
	parameter int PC_WIDTH = pdte_pkg::PC_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             req_type,
	input  wire logic [pdte_pkg::WORD_W-1:0]      next_pc,
	output logic                                  word_valid,
	input  wire logic                             word_stall,
	output logic      [pdte_pkg::WORD_W-1:0]      trace_word,
	output logic                                  last_word,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pdte_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [pdte_pkg::PDATA_W-1:0]     pwdata,
	output logic      [pdte_pkg::PDATA_W-1:0]     prdata,
	output logic                                  pready
);

	logic [pdte_pkg::COUNT_W-1:0] max_disc;
	logic                         room;
	pdte_pkg::push_t              push;

	pdte_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.max_disc (max_disc)
	);

	pdte_core #(
		.PC_WIDTH (PC_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.req_type   (req_type),
		.next_pc    (next_pc),
		.max_disc   (max_disc),
		.room       (room),
		.push       (push)
	);

	pdte_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.trace_word (trace_word),
		.last_word  (last_word)
	);

endmodule

`default_nettype wire

### hw/rtl/pdte_cfg.sv
// ----------------------------------------------------------------------------
// pdte_cfg
// apb register holding the discontinuity limit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdte_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pdte_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [pdte_pkg::PDATA_W-1:0]      pwdata,
	output logic      [pdte_pkg::PDATA_W-1:0]      prdata,
	output logic                                   pready,
	output logic      [pdte_pkg::COUNT_W-1:0]      max_disc
);

	logic [pdte_pkg::COUNT_W-1:0] max_disc_q;
	logic                         wr_en;

	// single register, every byte offset maps onto it
	assign wr_en  = psel & penable & pwrite & (paddr == paddr);
	assign pready = 1'b1;
	assign prdata = pdte_pkg::PDATA_W'(max_disc_q);
	assign max_disc = max_disc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_disc_q <= pdte_pkg::MAX_DISC_RST;
		end else if (wr_en) begin
			max_disc_q <= pwdata[pdte_pkg::COUNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pdte_core.sv
// ----------------------------------------------------------------------------
// pdte_core
// input register and trace encoding, one item per cycle while the result queue has room
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pc_discontinuity_trace_encoder_assert.svh"

module pdte_core #(
	parameter int PC_WIDTH = pdte_pkg::PC_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             req_type,
	input  wire logic [pdte_pkg::WORD_W-1:0]      next_pc,
	input  wire logic [pdte_pkg::COUNT_W-1:0]     max_disc,
	input  wire logic                             room,
	output pdte_pkg::push_t                       push
);

	logic                          valid_s1;
	logic                          req_s1;
	logic [pdte_pkg::WORD_W-1:0]   pc_s1;

	logic                          started_q;
	logic                          stopped_q;
	logic [PC_WIDTH-1:0]           last_pc_q;
	logic [pdte_pkg::COUNT_W-1:0]  jump_count_q;

	logic                          go;
	logic [PC_WIDTH-1:0]           pc_in;
	logic                          seq;
	logic                          at_limit;

	assign go         = valid_s1 & room;
	assign item_stall = valid_s1 & ~room;

	assign pc_in    = PC_WIDTH'(pc_s1);
	assign seq      = ((last_pc_q + PC_WIDTH'(pdte_pkg::PC_STEP)) == pc_in);
	assign at_limit = (jump_count_q >= max_disc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			req_s1 <= req_type;
			pc_s1  <= next_pc;
		end
	end

	always_comb begin
		push       = '0;
		push.word0 = pdte_pkg::WORD_W'(last_pc_q);
		push.last0 = 1'b1;
		push.word1 = pdte_pkg::WORD_W'(pc_in);
		if (go) begin
			if (req_s1) begin
				push.push0 = 1'b1;
			end else if (!stopped_q) begin
				if (!started_q) begin
					push.push0 = 1'b1;
					push.word0 = pdte_pkg::WORD_W'(pc_in);
				end else if (!seq) begin
					push.push0 = 1'b1;
					if (!at_limit) begin
						push.push1 = 1'b1;
						push.last0 = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			stopped_q    <= 1'b0;
			last_pc_q    <= '0;
			jump_count_q <= '0;
		end else if (go && !req_s1 && !stopped_q) begin
			started_q <= 1'b1;
			last_pc_q <= pc_in;
			if (started_q && !seq) begin
				if (at_limit) begin
					stopped_q <= 1'b1;
				end else begin
					jump_count_q <= jump_count_q + 1'b1;
				end
			end
		end
	end

	`PDTE_ASSERT_ALWAYS(a_stop_after_start, clk, arst_n, !stopped_q || started_q,
		"trace stopped before it started")
	`PDTE_ASSERT_ALWAYS(a_end_one_word, clk, arst_n,
		!(go && req_s1) || (push.push0 && !push.push1 && push.last0),
		"end request must give exactly one closing word")
	`PDTE_ASSERT_ALWAYS(a_pair_order, clk, arst_n, !push.push1 || (push.push0 && !push.last0),
		"second word without an open first word")
	`PDTE_ASSERT_NEXT(a_stopped_sticks, clk, arst_n, stopped_q, stopped_q,
		"stopped trace restarted")

endmodule

`default_nettype wire

### hw/rtl/pdte_fifo.sv
// ----------------------------------------------------------------------------
// pdte_fifo
// result queue taking up to two words per cycle and giving one beat per cycle while word_stall is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pc_discontinuity_trace_encoder_assert.svh"

module pdte_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pdte_pkg::push_t              push,
	output logic                              room,
	output logic                              word_valid,
	input  wire logic                         word_stall,
	output logic [pdte_pkg::WORD_W-1:0]       trace_word,
	output logic                              last_word
);

	pdte_pkg::entry_t                   mem [pdte_pkg::FIFO_DEPTH];
	logic [pdte_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [pdte_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [pdte_pkg::FIFO_CNT_W-1:0]    count_q;
	logic [pdte_pkg::FIFO_CNT_W-1:0]    n_push;
	logic                               pop;

	assign n_push     = pdte_pkg::FIFO_CNT_W'(push.push0) + pdte_pkg::FIFO_CNT_W'(push.push1);
	assign word_valid = (count_q != '0);
	assign pop        = word_valid & ~word_stall;
	assign room       = (count_q <= pdte_pkg::FIFO_CNT_W'(pdte_pkg::FIFO_DEPTH - 2));
	assign trace_word = mem[rd_ptr_q].word;
	assign last_word  = mem[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem[wr_ptr_q] <= '{word: push.word0, last: push.last0};
		end
		if (push.push1) begin
			mem[wr_ptr_q + 1'b1] <= '{word: push.word1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pdte_pkg::FIFO_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - pdte_pkg::FIFO_CNT_W'(pop);
		end
	end

	`PDTE_ASSERT_ALWAYS(a_no_overflow, clk, arst_n,
		(count_q + n_push) <= pdte_pkg::FIFO_CNT_W'(pdte_pkg::FIFO_DEPTH),
		"result queue overflow")
	`PDTE_ASSERT_ALWAYS(a_push_needs_room, clk, arst_n, !push.push0 || room,
		"word pushed without room")
	`PDTE_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && !push.push0 && (count_q == 1'b1),
		!word_valid, "queue not empty after last beat")

endmodule

`default_nettype wire

### tb/sv/pc_discontinuity_trace_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_discontinuity_trace_encoder_test
// drives retired next-pc values and end requests into the encoder, with
// random idling on both channels and long output hold-offs, predicts every
// trace word in-line and checks each beat of the word port against it;
// the limit register is written and read back at several settings, ending
// with a stopping jump and traffic on the stopped trace
// ----------------------------------------------------------------------------

module pc_discontinuity_trace_encoder_test;

	localparam logic REQ_RETIRE = 1'b0;
	localparam logic REQ_END    = 1'b1;
	localparam logic [pdte_pkg::PADDR_W-1:0] ADDR_MAX_DISC = '0;
	localparam int SETTLE      = 10;
	localparam int CYCLE_LIMIT = 1000000;

	logic                          clk;
	logic                          arst_n;
	logic                          item_valid;
	logic                          item_stall;
	logic                          req_type;
	logic [pdte_pkg::WORD_W-1:0]   next_pc;
	logic                          word_valid;
	logic                          word_stall;
	logic [pdte_pkg::WORD_W-1:0]   trace_word;
	logic                          last_word;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [pdte_pkg::PADDR_W-1:0]  paddr;
	logic [pdte_pkg::PDATA_W-1:0]  pwdata;
	logic [pdte_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	// encoder state as predicted
	logic                          mdl_started = 1'b0;
	logic [31:0]                   mdl_last_pc = '0;
	logic [15:0]                   mdl_jumps   = '0;
	logic                          mdl_stopped = 1'b0;
	logic [15:0]                   mdl_limit   = 16'hFFFF;

	pdte_pkg::entry_t              pending_trace_words[$];
	int                            errors = 0;
	int                            cycles = 0;
	bit                            sender_gaps = 1'b1;

	int                            hold_len = 0;
	int                            hold_seq = 0;
	int                            hold_seen = 0;
	int                            hold_left = 0;
	int                            stall_left = 0;
	int                            free_left = 0;
	int                            stall_pick;

	pc_discontinuity_trace_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.req_type   (req_type),
		.next_pc    (next_pc),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.trace_word (trace_word),
		.last_word  (last_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("pc_discontinuity_trace_encoder_test: done, errors");
			$finish;
		end
	end

	function automatic void note_error(input string what, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
	endfunction

	function automatic void encode_item(input logic req, input logic [31:0] pc);
		if (req == REQ_END) begin
			pending_trace_words.push_back(pdte_pkg::entry_t'{mdl_last_pc, 1'b1});
			return;
		end
		if (mdl_stopped)
			return;
		if (!mdl_started) begin
			mdl_started = 1'b1;
			mdl_last_pc = pc;
			pending_trace_words.push_back(pdte_pkg::entry_t'{pc, 1'b1});
			return;
		end
		if (mdl_last_pc + pdte_pkg::PC_STEP == pc) begin
			mdl_last_pc = pc;
			return;
		end
		if (mdl_jumps >= mdl_limit) begin
			pending_trace_words.push_back(pdte_pkg::entry_t'{mdl_last_pc, 1'b1});
			mdl_stopped = 1'b1;
			mdl_last_pc = pc;
			return;
		end
		pending_trace_words.push_back(pdte_pkg::entry_t'{mdl_last_pc, 1'b0});
		pending_trace_words.push_back(pdte_pkg::entry_t'{pc, 1'b1});
		mdl_jumps   = mdl_jumps + 16'd1;
		mdl_last_pc = pc;
	endfunction

	// word port checking
	always @(posedge clk) begin
		if (arst_n && word_valid && !word_stall) begin
			if (pending_trace_words.size() == 0) begin
				note_error("unexpected beat, word", 32'h0, trace_word);
			end else begin
				if (trace_word !== pending_trace_words[0].word)
					note_error("trace_word", pending_trace_words[0].word, trace_word);
				if (last_word !== pending_trace_words[0].last)
					note_error("last_word", {31'h0, pending_trace_words[0].last},
						{31'h0, last_word});
				void'(pending_trace_words.pop_front());
			end
		end
	end

	// word port stalls, with hold-offs on request
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left == 0 && stall_left == 0 && free_left == 0) begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 55)
				free_left = $urandom_range(1, 4);
			else if (stall_pick < 65)
				free_left = $urandom_range(20, 60);
			else if (stall_pick < 95)
				stall_left = $urandom_range(1, 3);
			else
				stall_left = $urandom_range(10, 30);
		end
		if (hold_left > 0) begin
			hold_left--;
			word_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			word_stall <= 1'b1;
		end else begin
			free_left--;
			word_stall <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] jump_target();
		logic [31:0] pc;
		case ($urandom_range(0, 5))
			0: pc = mdl_last_pc;
			1: pc = mdl_last_pc + 32'd8;
			2: pc = 32'hFFFF_FFF0 + 32'($urandom_range(0, 3) * 4);
			3: pc = mdl_last_pc - 32'd4;
			default: pc = $urandom;
		endcase
		if (pc == mdl_last_pc + pdte_pkg::PC_STEP)
			pc = pc ^ 32'h1;
		return pc;
	endfunction

	task automatic send_item(input logic req, input logic [31:0] pc);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		req_type   <= req;
		next_pc    <= pc;
		do @(posedge clk); while (item_stall);
		encode_item(req, pc);
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_trace_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		logic [31:0] junk;
		junk = $urandom;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MAX_DISC;
		pwdata  <= {junk[31:16], value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mdl_limit = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0, value})
			note_error("max_discontinuities readback", {16'h0, value}, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed();
		send_item(REQ_END, 32'h1234_5678);
		send_item(REQ_RETIRE, 32'hFFFF_FFF8);
		send_item(REQ_RETIRE, 32'hFFFF_FFFC);
		send_item(REQ_RETIRE, 32'h0000_0000);
		send_item(REQ_END, 32'hFFFF_FFFF);
		send_item(REQ_RETIRE, 32'h0000_0004);
		send_item(REQ_RETIRE, 32'hFFFF_FFFF);
		send_item(REQ_RETIRE, 32'h0000_0000);
		send_item(REQ_RETIRE, 32'h0000_0000);
		send_item(REQ_RETIRE, 32'h0000_0004);
		send_item(REQ_END, 32'h0000_0000);
		send_item(REQ_RETIRE, 32'h8000_0001);
		send_item(REQ_RETIRE, 32'h7FFF_FFFE);
		send_item(REQ_RETIRE, 32'h5555_5555);
		send_item(REQ_RETIRE, 32'hAAAA_AAAA);
		send_item(REQ_END, 32'h0000_0000);
		drain();
	endtask

	task automatic test_random_stream(input int count);
		int sent;
		int run;
		sent = 0;
		while (sent < count) begin
			sender_gaps = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 19))
				0: begin
					send_item(1'($urandom_range(0, 1)), $urandom);
					sent++;
				end
				1, 2: begin
					send_item(REQ_END, $urandom);
					sent++;
				end
				default: begin
					run = $urandom_range(0, 6);
					repeat (run) begin
						send_item(REQ_RETIRE, mdl_last_pc + pdte_pkg::PC_STEP);
						sent++;
					end
					send_item(REQ_RETIRE, jump_target());
					sent++;
				end
			endcase
		end
		sender_gaps = 1'b1;
		drain();
	endtask

	task automatic test_backpressure();
		hold_len = 200;
		hold_seq++;
		sender_gaps = 1'b0;
		repeat (40)
			send_item(REQ_RETIRE, jump_target());
		sender_gaps = 1'b1;
		drain();
	endtask

	task automatic test_limit_reached();
		write_limit(mdl_jumps + 16'd3);
		repeat (3) begin
			repeat ($urandom_range(0, 3))
				send_item(REQ_RETIRE, mdl_last_pc + pdte_pkg::PC_STEP);
			send_item(REQ_RETIRE, mdl_last_pc + 32'h100 + 32'($urandom_range(0, 4095)));
		end
		send_item(REQ_END, $urandom);
		drain();
		// zero limit, well below the recorded count: next jump stops the trace
		write_limit(16'h0);
		send_item(REQ_RETIRE, mdl_last_pc + pdte_pkg::PC_STEP);
		send_item(REQ_RETIRE, jump_target());
		send_item(REQ_END, $urandom);
		drain();
	endtask

	task automatic test_stopped(input int count);
		write_limit(16'hFFFF);
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: send_item(REQ_END, $urandom);
				1: send_item(REQ_RETIRE, mdl_last_pc + pdte_pkg::PC_STEP);
				default: send_item(REQ_RETIRE, $urandom);
			endcase
		end
		drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		req_type   = REQ_RETIRE;
		next_pc    = '0;
		word_stall = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(posedge clk);

		test_directed();
		write_limit(16'hFFFF);
		test_random_stream(500);
		test_backpressure();
		test_random_stream(500);
		test_limit_reached();
		test_stopped(80);

		if (errors == 0 && pending_trace_words.size() == 0)
			$display("pc_discontinuity_trace_encoder_test: done, clean");
		else
			$display("pc_discontinuity_trace_encoder_test: done, errors");
		$finish;
	end

endmodule
